// ===== hw/rtl/radix_integer_to_text_assert.svh =====
// Assertion macros for the radix conversion RTL.
`ifndef RADIX_INTEGER_TO_TEXT_ASSERT_SVH
`define RADIX_INTEGER_TO_TEXT_ASSERT_SVH

// Checks a property at every rising edge outside reset.
`define RIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define RIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rit_pkg.sv =====
// Types and constants of the radix integer-to-text converter.
`default_nettype none

package rit_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF = 96;
  localparam int unsigned VALUE_BITS_DEF  = 64;

  localparam int unsigned IN_VALUE_W = 64;
  localparam int unsigned SYMBOL_W   = 8;

  localparam logic [SYMBOL_W-1:0] CH_ZERO = 8'h30;
  localparam logic [SYMBOL_W-1:0] CH_LOW  = 8'h20;
  localparam logic [SYMBOL_W-1:0] CH_HIGH = 8'h7E;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_CONVERT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DIV,
    ST_EM_RD,
    ST_EM_SYM,
    ST_EM_OUT,
    ST_PUSH
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/radix_integer_to_text.sv =====
// Top level of the radix integer-to-text converter.
`default_nettype none

// Converts a signed integer into digit characters of a radix that the user
// defines by building a digit set. A clear item empties the set and an append
// item adds one printable symbol; an append of a symbol outside the printable
// range, of a symbol already present, or into a full table marks the set
// invalid until the next clear. A convert item with a valid set of at least two
// symbols produces one output item per digit, most significant first, each
// with the negative flag of the value and last set on the final digit. A zero
// value gives the single character '0'. An unusable set gives one item with
// status set. The minus sign is never sent as a character. The block takes one
// input item at a time and is not ready while an item is being worked on. An
// append into a non-empty set checks for a duplicate by reading the symbol
// table one entry at a time through its single read port. A convert runs
// each digit through the bit-serial divider, which divides the magnitude by
// the set size one quotient bit per cycle, and then reads the digit buffer
// and looks up the symbol. Results go through an output register, so the
// next input item is taken while the final result still waits for the
// consumer.

`include "radix_integer_to_text_assert.svh"

module radix_integer_to_text #(
  parameter int unsigned MAX_SYMBOLS = rit_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned VALUE_BITS  = rit_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            kind_i,
  input  logic [rit_pkg::SYMBOL_W-1:0]          symbol_i,
  input  logic signed [rit_pkg::IN_VALUE_W-1:0] value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rit_pkg::SYMBOL_W-1:0]          char_out_o,
  output logic                                  negative_o,
  output logic                                  last_o,
  output logic                                  status_o
);

  import rit_pkg::*;

  // Count of symbols, digit and table address, digit buffer index and fill.
  localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned AW = $clog2(MAX_SYMBOLS);
  localparam int unsigned IW = $clog2(VALUE_BITS);
  localparam int unsigned NW = $clog2(VALUE_BITS + 1);

  state_e state_q, state_d;

  logic [CW-1:0]         count_q, count_d;
  logic                  invalid_q, invalid_d;
  logic [SYMBOL_W-1:0]   sym_q, sym_d;
  logic [AW-1:0]         scan_q, scan_d;
  logic [NW-1:0]         ndig_q, ndig_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  neg_q, neg_d;
  logic [SYMBOL_W-1:0]   pend_char_q, pend_char_d;
  logic                  pend_status_q, pend_status_d;

  logic                  out_valid_q, out_valid_d;
  logic [SYMBOL_W-1:0]   out_char_q, out_char_d;
  logic                  out_neg_q, out_neg_d;
  logic                  out_last_q, out_last_d;
  logic                  out_status_q, out_status_d;
  logic                  out_load;
  logic                  out_free;

  // Symbol table and digit buffer, each with one write and one read port.
  logic [SYMBOL_W-1:0]   tbl_mem [MAX_SYMBOLS];
  logic                  tbl_we;
  logic [SYMBOL_W-1:0]   tbl_wdata;
  logic [AW-1:0]         tbl_raddr;
  logic [SYMBOL_W-1:0]   tbl_rd_q;
  logic [AW-1:0]         dbuf_mem [VALUE_BITS];
  logic                  dbuf_we;
  logic [AW-1:0]         dbuf_rd_q;

  logic                  in_acc;
  logic                  sym_bad;
  logic                  set_full;
  logic                  set_unusable;
  logic                  scan_last;
  logic [VALUE_BITS-1:0] val_u;
  logic                  val_neg;
  logic                  val_zero;
  logic [VALUE_BITS-1:0] mag;

  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quo;
  logic [CW-1:0]         div_rem;
  logic                  quo_zero;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign sym_bad      = (symbol_i < CH_LOW) || (symbol_i > CH_HIGH);
  assign set_full     = (count_q >= CW'(MAX_SYMBOLS));
  assign set_unusable = invalid_q || (count_q < CW'(2));
  assign scan_last    = (CW'(scan_q) + CW'(1)) == count_q;

  // Only the low VALUE_BITS bits count; the magnitude of the most negative
  // value still fits as an unsigned number.
  assign val_u    = value_i[VALUE_BITS-1:0];
  assign val_neg  = val_u[VALUE_BITS-1];
  assign val_zero = (val_u == '0);
  assign mag      = val_neg ? (~val_u + VALUE_BITS'(1)) : val_u;

  assign div_dividend = (state_q == ST_IDLE) ? mag : div_quo;
  assign quo_zero     = (div_quo == '0);

  rit_divider #(
    .W    (VALUE_BITS),
    .DIVW (CW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (count_q),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_e'(kind_i))
            KIND_APPEND: begin
              if (!invalid_q && !sym_bad && !set_full && (count_q != '0)) begin
                state_d = ST_SCAN_RD;
              end
            end
            KIND_CONVERT: begin
              if (set_unusable || val_zero) begin
                state_d = ST_PUSH;
              end else begin
                state_d = ST_DIV;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if ((tbl_rd_q == sym_q) || scan_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_DIV: begin
        if (div_done && quo_zero) begin
          state_d = ST_EM_RD;
        end
      end
      ST_EM_RD:  state_d = ST_EM_SYM;
      ST_EM_SYM: state_d = ST_EM_OUT;
      ST_EM_OUT: begin
        if (out_free) begin
          state_d = (idx_q == '0) ? ST_IDLE : ST_EM_RD;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    count_d       = count_q;
    invalid_d     = invalid_q;
    sym_d         = sym_q;
    scan_d        = scan_q;
    ndig_d        = ndig_q;
    idx_d         = idx_q;
    neg_d         = neg_q;
    pend_char_d   = pend_char_q;
    pend_status_d = pend_status_q;
    tbl_we        = 1'b0;
    tbl_wdata     = sym_q;
    dbuf_we       = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_char_d    = out_char_q;
    out_neg_d     = out_neg_q;
    out_last_d    = out_last_q;
    out_status_d  = out_status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_e'(kind_i))
            KIND_CLEAR: begin
              count_d   = '0;
              invalid_d = 1'b0;
            end
            KIND_APPEND: begin
              if (!invalid_q) begin
                if (sym_bad || set_full) begin
                  invalid_d = 1'b1;
                end else if (count_q == '0) begin
                  tbl_we    = 1'b1;
                  tbl_wdata = symbol_i;
                  count_d   = CW'(1);
                end else begin
                  sym_d  = symbol_i;
                  scan_d = '0;
                end
              end
            end
            KIND_CONVERT: begin
              if (set_unusable) begin
                pend_char_d   = '0;
                pend_status_d = 1'b1;
              end else if (val_zero) begin
                pend_char_d   = CH_ZERO;
                pend_status_d = 1'b0;
              end else begin
                neg_d     = val_neg;
                ndig_d    = '0;
                div_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_CMP: begin
        if (tbl_rd_q == sym_q) begin
          invalid_d = 1'b1;
        end else if (scan_last) begin
          tbl_we  = 1'b1;
          count_d = count_q + CW'(1);
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // Each remainder is one digit, least significant first.
          dbuf_we = 1'b1;
          ndig_d  = ndig_q + NW'(1);
          if (quo_zero) begin
            idx_d = ndig_q[IW-1:0];
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_EM_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_char_d   = tbl_rd_q;
          out_neg_d    = neg_q;
          out_last_d   = (idx_q == '0);
          out_status_d = 1'b0;
          idx_d        = idx_q - IW'(1);
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_char_d   = pend_char_q;
          out_neg_d    = 1'b0;
          out_last_d   = 1'b1;
          out_status_d = pend_status_q;
        end
      end
      default: ;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // The table is read for the duplicate scan and later addressed by digits.
  assign tbl_raddr = (state_q == ST_SCAN_RD) ? scan_q : dbuf_rd_q;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[count_q[AW-1:0]] <= tbl_wdata;
    end
    tbl_rd_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dbuf_we) begin
      dbuf_mem[ndig_q[IW-1:0]] <= div_rem[AW-1:0];
    end
    dbuf_rd_q <= dbuf_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      invalid_q   <= 1'b0;
      ndig_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      invalid_q   <= invalid_d;
      ndig_q      <= ndig_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q         <= sym_d;
    scan_q        <= scan_d;
    idx_q         <= idx_d;
    neg_q         <= neg_d;
    pend_char_q   <= pend_char_d;
    pend_status_q <= pend_status_d;
    out_char_q    <= out_char_d;
    out_neg_q     <= out_neg_d;
    out_last_q    <= out_last_d;
    out_status_q  <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;
  assign negative_o  = out_neg_q;
  assign last_o      = out_last_q;
  assign status_o    = out_status_q;

  `RIT_ASSERT(a_count_bound, count_q <= CW'(MAX_SYMBOLS), "symbol count beyond table size")
  `RIT_ASSERT(a_ready_div_idle, in_ready_o |-> !div_busy, "ready while divider busy")
  `RIT_ASSERT(a_rem_range, div_done |-> (div_rem < count_q), "remainder not below radix")
  `RIT_ASSERT(a_err_shape,
              (out_valid_o && status_o) |-> (last_o && !negative_o && (char_out_o == '0)),
              "malformed error result")
  `RIT_ASSERT_NEXT(a_last_idle, out_load && out_last_d, state_q == ST_IDLE,
                   "no return to idle after final result")

endmodule

`default_nettype wire

// ===== hw/rtl/rit_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module rit_divider #(
  parameter int unsigned W    = rit_pkg::VALUE_BITS_DEF,
  parameter int unsigned DIVW = $clog2(rit_pkg::MAX_SYMBOLS_DEF + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [W-1:0]    dividend_i,
  input  logic [DIVW-1:0] divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [W-1:0]    quotient_o,
  output logic [DIVW-1:0] remainder_o
);

  localparam int unsigned CNTW = $clog2(W + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [DIVW-1:0] rem_q, rem_d;
  logic [DIVW:0]   trial;
  logic [DIVW:0]   diff;
  logic            fits;

  // One shift-subtract step of the restoring division.
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = !diff[DIVW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[W-2:0], fits};
      rem_d = fits ? diff[DIVW-1:0] : trial[DIVW-1:0];
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== test/radix_integer_to_text_tb.sv =====
// Self-checking testbench for the radix integer-to-text converter.
`timescale 1ns / 1ps

module radix_integer_to_text_tb;
  import rit_pkg::*;

  // Kind 3 has no member in the package enum. The block must take it and do nothing.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [63:0] VALUE_MIN       = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VALUE_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VALUE_MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [7:0]  CH_ONE          = 8'h31;
  localparam logic [7:0]  CH_DEL          = 8'h7F;

  localparam int RANDOM_ITEMS = 420;
  // A radix-2 conversion of the most negative value divides out all of its
  // digits before the first one shows up. The limit must cover that quiet
  // stretch.
  localparam int QUIET_LIMIT  = 20000;
  // Drain time after the last expected digit, long enough for a full
  // 64-digit conversion, so that any stray output still gets caught.
  localparam int TAIL_CYCLES  = 4500;

  // One output item as the block should produce it.
  typedef struct packed {
    logic [7:0] ch;
    logic       neg;
    logic       last;
    logic       status;
  } text_item_t;

  // The single item that an unusable digit set produces.
  localparam text_item_t SET_UNUSABLE = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam text_item_t ZERO_TEXT    = '{CH_ZERO, 1'b0, 1'b1, 1'b0};
  localparam text_item_t NO_TEXT      = '{8'h00, 1'b0, 1'b0, 1'b0};

  // One row of the directed table. Where fixed is set, res is the only
  // item that row may produce, and it is typed in by hand.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sym;
    logic [63:0] val;
    logic        fixed;
    text_item_t  res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_CLEAR;
  logic [7:0]  symbol_i = 8'h00;
  logic [63:0] value_i = 64'h0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  char_out_o;
  logic        negative_o;
  logic        last_o;
  logic        status_o;

  radix_integer_to_text u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .symbol_i   (symbol_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_out_o (char_out_o),
    .negative_o (negative_o),
    .last_o     (last_o),
    .status_o   (status_o)
  );

  always #1 clk_i = ~clk_i;

  // Our own copy of the digit set.
  logic [7:0]  digit_set [MAX_SYMBOLS_DEF];
  int unsigned set_size = 0;
  bit          set_bad = 1'b0;

  text_item_t  spelled[$];       // items caused by the most recent input item
  text_item_t  awaited_text[$];  // items still owed by the block, oldest first
  stim_row_t   directed_rows[$];

  int  error_count = 0;
  int  items_done = 0;
  int  quiet_cycles = 0;
  bit  steady = 1'b0;            // when set, neither side idles
  text_item_t head;

  // Applies one input item to the digit set copy and fills spelled with the
  // items it should cause. Returns 0 when the block is expected to ignore it.
  function automatic bit spell_item(input logic [1:0] kind, input logic [7:0] sym,
                                    input logic [63:0] val);
    logic [6:0]  digits [64];
    logic [63:0] mag;
    logic [63:0] radix;
    logic        neg;
    text_item_t  r;
    int          n;
    spelled.delete();
    case (kind)
      KIND_CLEAR: begin
        set_size = 0;
        set_bad = 1'b0;
        return 1'b1;
      end
      KIND_APPEND: begin
        // Once the set is bad, appends leave no trace until the next clear.
        if (set_bad) return 1'b0;
        if (sym < CH_LOW || sym > CH_HIGH || set_size >= MAX_SYMBOLS_DEF) begin
          set_bad = 1'b1;
          return 1'b1;
        end
        for (int i = 0; i < set_size; i++) begin
          if (digit_set[i] == sym) begin
            set_bad = 1'b1;
            return 1'b1;
          end
        end
        digit_set[set_size] = sym;
        set_size++;
        return 1'b1;
      end
      KIND_CONVERT: begin
        if (set_bad || set_size < 2) begin
          spelled.push_back(SET_UNUSABLE);
          return 1'b1;
        end
        neg = val[63];
        // Two's complement negation also gets the most negative value right
        // when the result is read as unsigned.
        mag = neg ? (~val + 64'd1) : val;
        if (mag == 64'd0) begin
          spelled.push_back(ZERO_TEXT);
          return 1'b1;
        end
        radix = 64'(set_size);
        n = 0;
        while (mag != 64'd0) begin
          digits[n] = 7'(mag % radix);
          mag = mag / radix;
          n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
          r.ch = digit_set[digits[k]];
          r.neg = neg;
          r.last = (k == 0);
          r.status = 1'b0;
          spelled.push_back(r);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Mostly values of random length and sign, so that short and long digit
  // strings both show up, plus the extremes and fully random words.
  function automatic logic [63:0] draw_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 64'h0;
          1: v = 64'h1;
          2: v = VALUE_MINUS_ONE;
          3: v = VALUE_MIN;
          default: v = VALUE_MAX;
        endcase
      end
      1: v = {$urandom, $urandom};
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(1, 63);
        if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
      end
    endcase
    return v;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [7:0] sym,
                                  input logic [63:0] val, input logic fixed,
                                  input text_item_t res);
    stim_row_t row;
    row.kind = kind;
    row.sym = sym;
    row.val = val;
    row.fixed = fixed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  // Presents one input item after a random gap and returns at the edge where
  // it is taken. Valid is only lowered when a gap follows, so back-to-back
  // items keep valid high without a second assignment in the same step.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                           input logic [63:0] val, input logic fixed,
                           input text_item_t res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    symbol_i <= sym;
    value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // The item was taken at this edge. None of its output can be seen yet,
    // so the expectations are queued in time.
    void'(spell_item(kind, sym, val));
    if (fixed) begin
      awaited_text.push_back(res);
    end else begin
      foreach (spelled[i]) awaited_text.push_back(spelled[i]);
    end
    items_done++;
  endtask

  // Output side: random stalls before each item, none while steady is set.
  initial begin
    int stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Checks every output item against the oldest expectation and keeps the
  // watchdog, which only counts cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_text.size() == 0) begin
          $error("unexpected output item: char_out %h negative %b last %b status %b",
                 char_out_o, negative_o, last_o, status_o);
          error_count++;
        end else begin
          head = awaited_text.pop_front();
          if (char_out_o !== head.ch) begin
            $error("char_out: expected %h, actual %h", head.ch, char_out_o);
            error_count++;
          end
          if (negative_o !== head.neg) begin
            $error("negative: expected %b, actual %b", head.neg, negative_o);
            error_count++;
          end
          if (last_o !== head.last) begin
            $error("last: expected %b, actual %b", head.last, last_o);
            error_count++;
          end
          if (status_o !== head.status) begin
            $error("status: expected %b, actual %b", head.status, status_o);
            error_count++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [7:0] pool [95];
    logic [7:0] tmp;
    logic [7:0] bad;
    int         set_len;
    int         broken_at;
    int         converts;
    int         j;

    // Directed part. A convert right after reset sees an empty set; a single
    // symbol is still too small; a repeated symbol, a symbol below space and
    // one above tilde each spoil the set, and appends after that are ignored;
    // a spoiled set wins over a zero value; space and tilde themselves are
    // legal symbols; the two value extremes run against a binary set.
    add_row(KIND_CONVERT, 8'h00, 64'h0, 1'b1, SET_UNUSABLE);
    add_row(KIND_UNUSED,  8'hFF, VALUE_MINUS_ONE, 1'b0, NO_TEXT);
    add_row(KIND_APPEND,  CH_ZERO, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, 64'd5, 1'b1, SET_UNUSABLE);
    add_row(KIND_APPEND,  CH_ONE, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, 64'h0, 1'b1, ZERO_TEXT);
    add_row(KIND_CONVERT, 8'h00, 64'h1, 1'b1, '{CH_ONE, 1'b0, 1'b1, 1'b0});
    add_row(KIND_CONVERT, 8'h00, VALUE_MINUS_ONE, 1'b1, '{CH_ONE, 1'b1, 1'b1, 1'b0});
    add_row(KIND_CONVERT, 8'h00, VALUE_MAX, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, VALUE_MIN, 1'b0, NO_TEXT);
    add_row(KIND_APPEND,  CH_ONE, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, 64'd7, 1'b1, SET_UNUSABLE);
    add_row(KIND_APPEND,  8'h32, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, 64'h0, 1'b1, SET_UNUSABLE);
    add_row(KIND_CLEAR,   8'h00, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_APPEND,  8'h1F, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, 64'd3, 1'b1, SET_UNUSABLE);
    add_row(KIND_CLEAR,   8'h00, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_APPEND,  CH_LOW, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_APPEND,  CH_HIGH, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, 64'd5, 1'b0, NO_TEXT);
    add_row(KIND_APPEND,  CH_DEL, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, ~64'd4, 1'b1, SET_UNUSABLE);
    add_row(KIND_CLEAR,   8'h00, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_APPEND,  8'h00, 64'h0, 1'b0, NO_TEXT);
    add_row(KIND_CONVERT, 8'h00, VALUE_MIN, 1'b1, SET_UNUSABLE);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].sym, directed_rows[i].val,
                directed_rows[i].fixed, directed_rows[i].res);
    end

    // Random part: mostly well-formed sets followed by a few conversions,
    // with spoiled sets, stray kinds and odd sizes mixed in.
    for (int i = 0; i < 95; i++) pool[i] = CH_LOW + 8'(i);
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 5) == 0);

      for (int i = 94; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = pool[i];
        pool[i] = pool[j];
        pool[j] = tmp;
      end

      // Most sets are small. Now and then every printable symbol goes in.
      case ($urandom_range(0, 19))
        0: set_len = $urandom_range(0, 1);
        1: set_len = 95;
        2, 3, 4: set_len = $urandom_range(17, 60);
        default: set_len = $urandom_range(2, 16);
      endcase
      broken_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, set_len) : -1;

      if ($urandom_range(0, 7) != 0) begin
        send_item(KIND_CLEAR, 8'($urandom), {$urandom, $urandom}, 1'b0, NO_TEXT);
      end

      for (int k = 0; k <= set_len; k++) begin
        if (k == broken_at) begin
          case ($urandom_range(0, 2))
            0: bad = 8'($urandom_range(0, 31));
            1: bad = 8'($urandom_range(127, 255));
            default: bad = (k > 0) ? pool[$urandom_range(0, k - 1)] : 8'h00;
          endcase
          send_item(KIND_APPEND, bad, {$urandom, $urandom}, 1'b0, NO_TEXT);
        end
        if (k < set_len) begin
          send_item(KIND_APPEND, pool[k], {$urandom, $urandom}, 1'b0, NO_TEXT);
        end
      end

      // With every printable symbol taken, any further append is either out
      // of range or a repeat, so the set must turn bad.
      if (set_len == 95) begin
        send_item(KIND_APPEND, 8'($urandom), {$urandom, $urandom}, 1'b0, NO_TEXT);
      end

      if ($urandom_range(0, 9) == 0) begin
        send_item(KIND_UNUSED, 8'($urandom), {$urandom, $urandom}, 1'b0, NO_TEXT);
      end

      converts = $urandom_range(1, 4);
      repeat (converts) begin
        send_item(KIND_CONVERT, 8'($urandom), draw_value(), 1'b0, NO_TEXT);
      end
    end

    in_valid_i <= 1'b0;
    steady = 1'b0;
    while (awaited_text.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rit_pkg.sv
hw/rtl/rit_divider.sv
hw/rtl/radix_integer_to_text.sv
test/radix_integer_to_text_tb.sv
